// File: rtl/mec_pkg.sv
package mec_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int PIX_W     = 12;
  localparam int LIMIT_W   = 16;
  localparam int HEIGHT_W  = 13;
  localparam int INDEX_W   = 24;
  localparam int CFG_IDX_W = 3;

  // Register reset values
  localparam logic [COORD_W-1:0]  X_ORIGIN_RST = 32'hE000_0000;  // -2.0 in Q28
  localparam logic [COORD_W-1:0]  Y_ORIGIN_RST = 32'hE000_0000;
  localparam logic [STEP_W-1:0]   STEP_RST     = 31'd2684355;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST    = 16'd100;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 13'd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN      = 3'd0,
    REG_Y_ORIGIN      = 3'd1,
    REG_STEP_SIZE     = 3'd2,
    REG_ITER_LIMIT    = 3'd3,
    REG_COLUMN_HEIGHT = 3'd4
  } mec_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } mec_state_t;

  // Control and constant part of a pixel traveling around the ring
  typedef struct packed {
    logic               valid;
    logic               done;
    logic [LIMIT_W-1:0] count;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } mec_beat_t;

  // Mapped pixel leaving the coordinate front end
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [INDEX_W-1:0] idx;
  } mec_map_t;

  // Width of z components: room for c plus a term of magnitude up to 4.0
  function automatic int mec_zw(int frac);
    return ((frac + 4 > COORD_W) ? frac + 4 : COORD_W) + 1;
  endfunction

endpackage

// File: rtl/mec_map.sv
module mec_map
  import mec_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [PIX_W-1:0]    pixel_column,
  input  logic [PIX_W-1:0]    pixel_row,
  input  logic [COORD_W-1:0]  x_origin,
  input  logic [COORD_W-1:0]  y_origin,
  input  logic [STEP_W-1:0]   step_size,
  input  logic [HEIGHT_W-1:0] column_height,
  output mec_map_t            map_out
);

  localparam int CPROD_W = PIX_W + STEP_W;
  localparam int HPROD_W = PIX_W + HEIGHT_W;

  logic [CPROD_W-1:0] cx_prod, cy_prod;
  logic [HPROD_W-1:0] idx_prod;

  logic               s1_valid_r;
  logic [COORD_W-1:0] s1_cx_off_r, s1_cy_off_r;
  logic [INDEX_W-1:0] s1_idx_r;
  logic [PIX_W-1:0]   s1_row_r;
  mec_map_t           map_r;

  // stage 1: offsets from the origin, column part of the index
  always_comb begin
    cx_prod  = pixel_column * step_size;
    cy_prod  = pixel_row * step_size;
    idx_prod = pixel_column * column_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= load;
    end
    if (load) begin
      s1_cx_off_r <= cx_prod[COORD_W-1:0];
      s1_cy_off_r <= cy_prod[COORD_W-1:0];
      s1_idx_r    <= idx_prod[INDEX_W-1:0];
      s1_row_r    <= pixel_row;
    end
  end

  // stage 2: wrap-around coordinate sums; held until the next pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r.valid <= 1'b0;
    end else begin
      map_r.valid <= s1_valid_r;
    end
    if (s1_valid_r) begin
      map_r.cx  <= x_origin + s1_cx_off_r;
      map_r.cy  <= y_origin + s1_cy_off_r;
      map_r.idx <= s1_idx_r + INDEX_W'(s1_row_r);
    end
  end

  assign map_out = map_r;

endmodule

// File: rtl/mec_cell.sv
module mec_cell
  import mec_pkg::*;
#(
  parameter  int FRACTION_BITS = 28,
  localparam int ZW            = mec_zw(FRACTION_BITS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [LIMIT_W-1:0]   iter_limit,
  input  mec_beat_t            in_beat,
  input  logic signed [ZW-1:0] in_x,
  input  logic signed [ZW-1:0] in_y,
  output mec_beat_t            out_beat,
  output logic signed [ZW-1:0] out_x,
  output logic signed [ZW-1:0] out_y
);

  localparam int PW    = 2 * ZW;
  localparam int SW    = PW + 1;
  localparam int EXT_W = ZW - COORD_W;
  localparam logic [SW-1:0] ESC_TH = SW'(1) << (2 * FRACTION_BITS + 2);  // 4.0

  mec_beat_t             a_beat_r, a_beat_nxt;
  logic signed [ZW-1:0]  a_x_r, a_y_r;
  logic signed [PW-1:0]  a_xx_r, a_yy_r, a_xy_r;
  logic signed [PW-1:0]  a_xx_nxt, a_yy_nxt, a_xy_nxt;

  mec_beat_t             b_beat_r, b_beat_nxt;
  logic signed [ZW-1:0]  b_x_r, b_y_r, b_x_nxt, b_y_nxt;

  logic [SW-1:0]         sq_sum;
  logic signed [PW-1:0]  sq_diff, re_sh, im_sh;
  logic                  escape;

  // stage A: squares and cross product; limit check
  always_comb begin
    a_beat_nxt      = in_beat;
    a_beat_nxt.done = in_beat.done | (in_beat.count == iter_limit);
    a_xx_nxt        = in_x * in_x;
    a_yy_nxt        = in_y * in_y;
    a_xy_nxt        = in_x * in_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_beat_r.valid <= 1'b0;
    end else begin
      a_beat_r <= a_beat_nxt;
    end
    a_x_r  <= in_x;
    a_y_r  <= in_y;
    a_xx_r <= a_xx_nxt;
    a_yy_r <= a_yy_nxt;
    a_xy_r <= a_xy_nxt;
  end

  // stage B: exact escape test, then z = z*z + c
  always_comb begin
    sq_sum  = {1'b0, a_xx_r} + {1'b0, a_yy_r};
    escape  = sq_sum > ESC_TH;
    sq_diff = a_xx_r - a_yy_r;
    re_sh   = sq_diff >>> FRACTION_BITS;
    im_sh   = a_xy_r >>> (FRACTION_BITS - 1);  // 2xy

    b_beat_nxt = a_beat_r;
    b_x_nxt    = a_x_r;
    b_y_nxt    = a_y_r;
    if (a_beat_r.valid && !a_beat_r.done) begin
      if (escape) begin
        b_beat_nxt.done = 1'b1;
      end else begin
        b_x_nxt = re_sh[ZW-1:0] + {{EXT_W{a_beat_r.cx[COORD_W-1]}}, a_beat_r.cx};
        b_y_nxt = im_sh[ZW-1:0] + {{EXT_W{a_beat_r.cy[COORD_W-1]}}, a_beat_r.cy};
        b_beat_nxt.count = a_beat_r.count + LIMIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_beat_r.valid <= 1'b0;
    end else begin
      b_beat_r <= b_beat_nxt;
    end
    b_x_r <= b_x_nxt;
    b_y_r <= b_y_nxt;
  end

  assign out_beat = b_beat_r;
  assign out_x    = b_x_r;
  assign out_y    = b_y_r;

endmodule

// File: rtl/mandelbrot_escape_count.sv
// Mandelbrot escape-time counter. Each input beat names one pixel by column and row;
// the block maps it to c = origin + index * step (Q.FRACTION_BITS, wrapping at 32 bits),
// iterates z = z*z + c from z = c until |z|^2 > 4 or iteration_limit is reached, and
// returns one result beat: the escape count and column * column_height + row. One pixel
// is in work at a time. It runs around a ring of NUM_CELLS iteration cells, each doing
// one iteration in two register stages (multiply stage, then add/compare stage). A pixel
// that completes n iterations needs n+1 cell visits; the next pixel is accepted once it
// has left the ring. A finished result waits in the output register while the next
// pixel is taken in; if that register still holds an unaccepted result, the finished
// pixel laps the ring again.
// Configuration writes are accepted at any time but must only be issued while idle.
module mandelbrot_escape_count
  import mec_pkg::*;
#(
  parameter int FRACTION_BITS = 28,
  parameter int NUM_CELLS     = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel_column,
  input  logic [PIX_W-1:0]     in_pixel_row,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LIMIT_W-1:0]   out_escape_count,
  output logic [INDEX_W-1:0]   out_result_index,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam int ZW    = mec_zw(FRACTION_BITS);
  localparam int EXT_W = ZW - COORD_W;

  // Configuration registers
  logic [COORD_W-1:0]  x_origin_r, y_origin_r;
  logic [STEP_W-1:0]   step_size_r;
  logic [LIMIT_W-1:0]  iter_limit_r;
  logic [HEIGHT_W-1:0] column_height_r;

  mec_state_t          state_r, state_nxt;
  logic                in_accept;

  mec_map_t            map_beat;

  mec_beat_t            cell_in  [NUM_CELLS];
  mec_beat_t            cell_out [NUM_CELLS];
  logic signed [ZW-1:0] cell_in_x  [NUM_CELLS];
  logic signed [ZW-1:0] cell_in_y  [NUM_CELLS];
  logic signed [ZW-1:0] cell_out_x [NUM_CELLS];
  logic signed [ZW-1:0] cell_out_y [NUM_CELLS];
  logic [NUM_CELLS-1:0] ring_valid;

  mec_beat_t            head_beat, tail_beat;
  logic signed [ZW-1:0] head_x, head_y;
  logic                 out_free, item_exit;

  logic                 out_valid_r;
  logic [LIMIT_W-1:0]   out_escape_count_r;
  logic [INDEX_W-1:0]   out_result_index_r;

  // Config write port: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r      <= X_ORIGIN_RST;
      y_origin_r      <= Y_ORIGIN_RST;
      step_size_r     <= STEP_RST;
      iter_limit_r    <= LIMIT_RST;
      column_height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (mec_reg_t'(cfg_index))
        REG_X_ORIGIN:      x_origin_r      <= cfg_data;
        REG_Y_ORIGIN:      y_origin_r      <= cfg_data;
        REG_STEP_SIZE:     step_size_r     <= cfg_data[STEP_W-1:0];
        REG_ITER_LIMIT:    iter_limit_r    <= cfg_data[LIMIT_W-1:0];
        REG_COLUMN_HEIGHT: column_height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // One pixel in work at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_BUSY;
      ST_BUSY: if (item_exit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  // Coordinate front end: two register stages
  mec_map u_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_accept),
    .pixel_column  (in_pixel_column),
    .pixel_row     (in_pixel_row),
    .x_origin      (x_origin_r),
    .y_origin      (y_origin_r),
    .step_size     (step_size_r),
    .column_height (column_height_r),
    .map_out       (map_beat)
  );

  // Ring head: inject a freshly mapped pixel or recirculate the tail.
  // A finished pixel leaves only when the output register is free; otherwise
  // it rides around again unchanged.
  assign tail_beat = cell_out[NUM_CELLS-1];
  assign out_free  = !out_valid_r || out_ready;
  assign item_exit = tail_beat.valid && tail_beat.done && out_free;

  always_comb begin
    if (map_beat.valid) begin
      head_beat.valid = 1'b1;
      head_beat.done  = 1'b0;
      head_beat.count = '0;
      head_beat.cx    = map_beat.cx;
      head_beat.cy    = map_beat.cy;
      head_x = {{EXT_W{map_beat.cx[COORD_W-1]}}, map_beat.cx};
      head_y = {{EXT_W{map_beat.cy[COORD_W-1]}}, map_beat.cy};
    end else begin
      head_beat       = tail_beat;
      head_beat.valid = tail_beat.valid && !item_exit;
      head_x          = cell_out_x[NUM_CELLS-1];
      head_y          = cell_out_y[NUM_CELLS-1];
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i]   = head_beat;
      assign cell_in_x[i] = head_x;
      assign cell_in_y[i] = head_y;
    end else begin : g_link
      assign cell_in[i]   = cell_out[i-1];
      assign cell_in_x[i] = cell_out_x[i-1];
      assign cell_in_y[i] = cell_out_y[i-1];
    end

    mec_cell #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .iter_limit (iter_limit_r),
      .in_beat    (cell_in[i]),
      .in_x       (cell_in_x[i]),
      .in_y       (cell_in_y[i]),
      .out_beat   (cell_out[i]),
      .out_x      (cell_out_x[i]),
      .out_y      (cell_out_y[i])
    );

    assign ring_valid[i] = cell_out[i].valid;
  end

  // Output register; index stays parked in the front end until exit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_exit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (item_exit) begin
      out_escape_count_r <= tail_beat.count;
      out_result_index_r <= map_beat.idx;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_escape_count = out_escape_count_r;
  assign out_result_index = out_result_index_r;

  // Checks
  a_single_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ring_valid))
    else $error("more than one pixel in the ring");

  a_inject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    map_beat.valid |-> (ring_valid == '0))
    else $error("pixel injected into a busy ring");

  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    item_exit |-> (state_r == ST_BUSY) && !map_beat.valid)
    else $error("result leaves ring while no pixel is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_escape_count_r <= iter_limit_r))
    else $error("escape count above iteration limit");

endmodule
